### hdl/nos_pkg.sv
`default_nettype none
package nos_pkg;

    localparam int IMAGE_SIDE   = 512;
    localparam int CORDIC_STEPS = 16;

    localparam int CENTRE = IMAGE_SIDE / 2;
    localparam int CW     = $clog2(IMAGE_SIDE);
    localparam int DW     = $clog2(2 * CENTRE * CENTRE + 1);
    localparam int AMW    = ((CW > 8) ? CW : 8) + 1;

    // cordic datapath
    localparam int CSH     = 10;
    localparam int XW      = $clog2(CENTRE + 1) + CSH + 3;
    localparam int ZW      = 25;
    localparam int ATAN_N  = 24;
    localparam int CORD_IW = $clog2(ATAN_N);
    localparam int NSTEP   = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;

    // atan(2^-i) in 1/65536 degree
    localparam int ATAN_TABLE [ATAN_N] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // field widths
    localparam int COLOR_W = 8;
    localparam int ANG_W   = 16;
    localparam int SPD_W   = 11;
    localparam int FOUND_W = 2;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 10;
    localparam logic [CFG_IW-1:0] REG_BLUE_MAX    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_GREEN_MAX   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_RED_MIN     = 3'd2;
    localparam logic [CFG_IW-1:0] REG_BASE_SPEED  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_STEER_GAIN  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_SPEED_LIMIT = 3'd5;
    localparam logic [CFG_IW-1:0] REG_AIM_ROW     = 3'd6;

    // smoothing and gain arithmetic
    localparam int SMOOTH_PREV = 45875;
    localparam int SMOOTH_RAW  = 19661;
    localparam int MUL_AW  = 17;
    localparam int MUL_BW  = 16;
    localparam int MUL_PW  = MUL_AW + MUL_BW;
    localparam int ACC_W   = MUL_PW + 1;
    localparam int PROD_W  = 21;
    localparam int KW      = PROD_W - 8;
    localparam int SPW     = 14;

    typedef struct packed {
        logic [COLOR_W-1:0] blue_max;
        logic [COLOR_W-1:0] green_max;
        logic [COLOR_W-1:0] red_min;
    } t_thresh;

    typedef struct packed {
        logic          left_seen;
        logic          right_seen;
        logic [CW-1:0] left_col;
        logic [CW-1:0] right_col;
    } t_track;

    typedef struct packed {
        logic                    done;
        logic signed [ANG_W-1:0] angle;
    } t_cordic_res;

endpackage
`default_nettype wire

### hdl/nos_if.sv
`default_nettype none
interface nos_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [nos_pkg::COLOR_W-1:0]   blue;
    logic [nos_pkg::COLOR_W-1:0]   green;
    logic [nos_pkg::COLOR_W-1:0]   red;
    logic                          frame_last;
    logic                          drive_enable;

    modport source (output valid, blue, green, red, frame_last, drive_enable, input ready);
    modport sink   (input valid, blue, green, red, frame_last, drive_enable, output ready);
endinterface

interface nos_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [nos_pkg::SPD_W-1:0]     left_speed;
    logic signed [nos_pkg::SPD_W-1:0]     right_speed;
    logic signed [nos_pkg::ANG_W-1:0]     heading_error_fine;
    logic [nos_pkg::FOUND_W-1:0]          obstacles_found;

    modport source (output valid, left_speed, right_speed, heading_error_fine,
                    obstacles_found, input ready);
    modport sink   (input valid, left_speed, right_speed, heading_error_fine,
                    obstacles_found, output ready);
endinterface

interface nos_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [nos_pkg::CFG_IW-1:0]    index;
    logic [nos_pkg::CFG_DW-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/nos_track.sv
`default_nettype none
module nos_track (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_beat,
    input  logic [nos_pkg::COLOR_W-1:0]   i_blue,
    input  logic [nos_pkg::COLOR_W-1:0]   i_green,
    input  logic [nos_pkg::COLOR_W-1:0]   i_red,
    input  logic                          i_last,
    input  logic                          i_clear,
    input  nos_pkg::t_thresh              i_thresh,
    output nos_pkg::t_track               o_track
);

    localparam int CW = nos_pkg::CW;
    localparam int DW = nos_pkg::DW;
    localparam logic [DW-1:0] C2 = DW'(nos_pkg::CENTRE * nos_pkg::CENTRE);
    localparam logic [CW-1:0] LAST_POS = CW'(nos_pkg::IMAGE_SIDE - 1);
    localparam logic [CW-1:0] CEN = CW'(nos_pkg::CENTRE);

    logic [CW-1:0] r_col, n_col, r_row, n_row;
    logic [DW-1:0] r_dx2, n_dx2, r_dy2, n_dy2;
    logic [DW-1:0] r_lbest, n_lbest, r_rbest, n_rbest;
    logic [CW-1:0] r_lcol, n_lcol, r_rcol, n_rcol;
    logic          r_lseen, n_lseen, r_rseen, n_rseen;

    logic                 hit;
    logic [DW-1:0]        cur_dist;
    logic signed [CW:0]   dcol, drow;
    logic signed [DW:0]   dx2_next, dy2_next;

    assign hit = (i_blue <= i_thresh.blue_max) && (i_green <= i_thresh.green_max) &&
                 (i_red >= i_thresh.red_min);
    assign cur_dist = r_dx2 + r_dy2;

    // squares tracked incrementally: (d+1)^2 = d^2 + 2d + 1
    assign dcol = $signed({1'b0, r_col}) - $signed({1'b0, CEN});
    assign drow = $signed({1'b0, r_row}) - $signed({1'b0, CEN});
    assign dx2_next = $signed({1'b0, r_dx2}) + (DW+1)'($signed({dcol, 1'b1}));
    assign dy2_next = $signed({1'b0, r_dy2}) + (DW+1)'($signed({drow, 1'b1}));

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_dx2   = r_dx2;
        n_dy2   = r_dy2;
        n_lbest = r_lbest;
        n_rbest = r_rbest;
        n_lcol  = r_lcol;
        n_rcol  = r_rcol;
        n_lseen = r_lseen;
        n_rseen = r_rseen;
        if (i_beat) begin
            if (hit && (r_row < CEN)) begin
                if (r_col < CEN) begin
                    if (!r_lseen || (cur_dist < r_lbest)) begin
                        n_lbest = cur_dist;
                        n_lcol  = r_col;
                        n_lseen = 1'b1;
                    end
                end else begin
                    if (!r_rseen || (cur_dist < r_rbest)) begin
                        n_rbest = cur_dist;
                        n_rcol  = r_col;
                        n_rseen = 1'b1;
                    end
                end
            end
            if (i_last) begin
                n_col = '0;
                n_row = '0;
                n_dx2 = C2;
                n_dy2 = C2;
            end else if (r_col == LAST_POS) begin
                n_col = '0;
                n_dx2 = C2;
                if (r_row == LAST_POS) begin
                    n_row = '0;
                    n_dy2 = C2;
                end else begin
                    n_row = r_row + CW'(1);
                    n_dy2 = dy2_next[DW-1:0];
                end
            end else begin
                n_col = r_col + CW'(1);
                n_dx2 = dx2_next[DW-1:0];
            end
        end
        if (i_clear) begin
            n_lbest = '1;
            n_rbest = '1;
            n_lcol  = '0;
            n_rcol  = '0;
            n_lseen = 1'b0;
            n_rseen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_dx2   <= C2;
            r_dy2   <= C2;
            r_lbest <= '1;
            r_rbest <= '1;
            r_lcol  <= '0;
            r_rcol  <= '0;
            r_lseen <= 1'b0;
            r_rseen <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_dx2   <= n_dx2;
            r_dy2   <= n_dy2;
            r_lbest <= n_lbest;
            r_rbest <= n_rbest;
            r_lcol  <= n_lcol;
            r_rcol  <= n_rcol;
            r_lseen <= n_lseen;
            r_rseen <= n_rseen;
        end
    end

    assign o_track.left_seen  = r_lseen;
    assign o_track.right_seen = r_rseen;
    assign o_track.left_col   = r_lcol;
    assign o_track.right_col  = r_rcol;

endmodule
`default_nettype wire

### hdl/nos_cordic.sv
`default_nettype none
module nos_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [nos_pkg::CW:0]   i_dx,
    input  logic [nos_pkg::CW-1:0]        i_dy,
    output nos_pkg::t_cordic_res          o_res
);

    localparam int CW  = nos_pkg::CW;
    localparam int XW  = nos_pkg::XW;
    localparam int ZW  = nos_pkg::ZW;
    localparam int IW  = nos_pkg::CORD_IW;
    localparam int CSH = nos_pkg::CSH;
    localparam logic [IW-1:0] I_LAST = IW'(nos_pkg::NSTEP - 1);

    logic                 r_busy, r_done;
    logic [IW-1:0]        r_i;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;

    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] ang, zr;

    // one shift-add step per cycle, shifts floor
    assign xs  = r_x >>> r_i;
    assign ys  = r_y >>> r_i;
    assign ang = ZW'(nos_pkg::ATAN_TABLE[r_i]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == I_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= $signed({{(XW-CW-CSH){1'b0}}, i_dy, {CSH{1'b0}}});
            r_y <= $signed({{(XW-CW-CSH-1){i_dx[CW]}}, i_dx, {CSH{1'b0}}});
            r_z <= '0;
        end else if (r_busy) begin
            if (!r_y[XW-1]) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + ang;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - ang;
            end
        end
    end

    // round to 1/256 degree
    assign zr = r_z + ZW'(128);
    assign o_res.done  = r_done;
    assign o_res.angle = zr[8 +: nos_pkg::ANG_W];

endmodule
`default_nettype wire

### hdl/nearest_obstacle_steering.sv
`default_nettype none
// Pixels of one square frame stream in on i_pix in raster order, one beat per cycle, and the
// block keeps the obstacle-coloured pixel nearest the image centre in the top half, once for
// the left and once for the right side. On the beat that carries frame_last it stops taking
// pixels while one shared shift-add unit runs the CORDIC atan2 (one step per cycle,
// CORDIC_STEPS steps) and one multiplier does the smoothing and gain in turn: i_pix.ready is
// low through the init state, the CORDIC when both sides were found, the two smoothing
// products, the gain product and the output state, longer only if the previous result beat
// is still waiting on o_res. The result register lets the next frame stream in while a
// result waits. Configuration beats on i_cfg are always taken; write them between frames.
module nearest_obstacle_steering (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nos_pixel_if.sink     i_pix,
    nos_result_if.source  o_res,
    nos_cfg_if.sink       i_cfg
);

    localparam int CW     = nos_pkg::CW;
    localparam int AMW    = nos_pkg::AMW;
    localparam int ANG_W  = nos_pkg::ANG_W;
    localparam int ACC_W  = nos_pkg::ACC_W;
    localparam int PROD_W = nos_pkg::PROD_W;
    localparam int KW     = nos_pkg::KW;
    localparam int SPW    = nos_pkg::SPW;
    localparam int SPD_W  = nos_pkg::SPD_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_CORD = 3'd2;
    localparam logic [2:0] S_MUL0 = 3'd3;
    localparam logic [2:0] S_MUL1 = 3'd4;
    localparam logic [2:0] S_GAIN = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // configuration registers
    logic [7:0] r_blue_max, r_green_max, r_red_min, r_aim_row;
    logic [9:0] r_base_speed, r_speed_limit;
    logic [3:0] r_steer_gain;

    logic [2:0]                    r_state, n_state;
    logic [nos_pkg::FOUND_W-1:0]   r_found;
    logic                          r_drive;
    logic signed [ANG_W-1:0]       r_raw, r_prev;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [PROD_W-1:0]      r_prod;

    logic                          r_out_valid;
    logic signed [SPD_W-1:0]       r_left, r_right;
    logic signed [ANG_W-1:0]       r_heading;
    logic [nos_pkg::FOUND_W-1:0]   r_out_found;

    logic pix_beat, cfg_beat, load_out, both_seen;

    nos_pkg::t_thresh     thresh;
    nos_pkg::t_track      track;
    nos_pkg::t_cordic_res cres;

    logic [CW:0]              mid_sum;
    logic [CW-1:0]            mid;
    logic signed [CW:0]       dx;
    logic [CW-1:0]            dy;
    logic [AMW-1:0]           aim_ext, cen_ext, dy_full;

    logic signed [nos_pkg::MUL_AW-1:0] mul_a;
    logic signed [nos_pkg::MUL_BW-1:0] mul_b;
    logic signed [nos_pkg::MUL_PW-1:0] prod;
    logic signed [ANG_W-1:0]           smooth_new;

    logic signed [PROD_W-1:0] kq;
    logic signed [KW-1:0]     k;
    logic signed [SPW-1:0]    base_s, k_s, lim_s, l_raw, r_rawspd;
    logic signed [SPD_W-1:0]  l_clamp, r_clamp;

    function automatic logic signed [SPD_W-1:0] clamp_speed(
        input logic signed [SPW-1:0] v,
        input logic signed [SPW-1:0] lim
    );
        logic signed [SPW-1:0] res;
        res = v;
        if (v > lim) begin
            res = lim;
        end else if (v < -lim) begin
            res = -lim;
        end
        return res[SPD_W-1:0];
    endfunction

    assign pix_beat    = i_pix.valid && i_pix.ready;
    assign cfg_beat    = i_cfg.valid && i_cfg.ready;
    assign i_pix.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blue_max    <= 8'd50;
            r_green_max   <= 8'd50;
            r_red_min     <= 8'd200;
            r_base_speed  <= 10'd100;
            r_steer_gain  <= 4'd1;
            r_speed_limit <= 10'd300;
            r_aim_row     <= 8'd10;
        end else if (cfg_beat) begin
            unique case (i_cfg.index)
                nos_pkg::REG_BLUE_MAX:    r_blue_max    <= i_cfg.data[7:0];
                nos_pkg::REG_GREEN_MAX:   r_green_max   <= i_cfg.data[7:0];
                nos_pkg::REG_RED_MIN:     r_red_min     <= i_cfg.data[7:0];
                nos_pkg::REG_BASE_SPEED:  r_base_speed  <= i_cfg.data[9:0];
                nos_pkg::REG_STEER_GAIN:  r_steer_gain  <= i_cfg.data[3:0];
                nos_pkg::REG_SPEED_LIMIT: r_speed_limit <= i_cfg.data[9:0];
                nos_pkg::REG_AIM_ROW:     r_aim_row     <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    assign thresh.blue_max  = r_blue_max;
    assign thresh.green_max = r_green_max;
    assign thresh.red_min   = r_red_min;

    nos_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (pix_beat),
        .i_blue   (i_pix.blue),
        .i_green  (i_pix.green),
        .i_red    (i_pix.red),
        .i_last   (i_pix.frame_last),
        .i_clear  (r_state == S_INIT),
        .i_thresh (thresh),
        .o_track  (track)
    );

    // aim geometry
    assign both_seen = track.left_seen && track.right_seen;
    assign mid_sum   = {1'b0, track.left_col} + {1'b0, track.right_col};
    assign mid       = mid_sum[CW:1];
    assign dx        = $signed({1'b0, mid}) - $signed((CW+1)'(nos_pkg::CENTRE));
    assign aim_ext   = AMW'(r_aim_row);
    assign cen_ext   = AMW'(nos_pkg::CENTRE);
    assign dy_full   = cen_ext - aim_ext;
    // aim row at or below centre saturates to one
    assign dy        = (aim_ext >= cen_ext) ? CW'(1) : dy_full[CW-1:0];

    nos_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_INIT) && both_seen),
        .i_dx    (dx),
        .i_dy    (dy),
        .o_res   (cres)
    );

    // shared multiplier
    assign smooth_new = $signed(r_acc[16 +: ANG_W]);

    always_comb begin
        case (r_state)
            S_MUL0: begin
                mul_a = nos_pkg::MUL_AW'(nos_pkg::SMOOTH_PREV);
                mul_b = r_prev;
            end
            S_MUL1: begin
                mul_a = nos_pkg::MUL_AW'(nos_pkg::SMOOTH_RAW);
                mul_b = r_raw;
            end
            default: begin
                mul_a = $signed({{(nos_pkg::MUL_AW-4){1'b0}}, r_steer_gain});
                mul_b = smooth_new;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // gain term truncates toward zero
    assign kq     = r_prod + (r_prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
    assign k      = kq[PROD_W-1:8];
    assign base_s = $signed({{(SPW-10){1'b0}}, r_base_speed});
    assign lim_s  = $signed({{(SPW-10){1'b0}}, r_speed_limit});
    assign k_s    = SPW'(k);
    assign l_raw  = base_s - k_s;
    assign r_rawspd = -(base_s + k_s);
    assign l_clamp  = clamp_speed(l_raw, lim_s);
    assign r_clamp  = clamp_speed(r_rawspd, lim_s);

    assign load_out = (r_state == S_OUT) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (pix_beat && i_pix.frame_last) n_state = S_INIT;
            S_INIT: n_state = both_seen ? S_CORD : S_MUL0;
            S_CORD: if (cres.done) n_state = S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_GAIN;
            S_GAIN: n_state = S_OUT;
            S_OUT:  if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_GAIN) begin
                r_prev <= smooth_new;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_beat && i_pix.frame_last) begin
            r_drive <= i_pix.drive_enable;
        end
        if (r_state == S_INIT) begin
            r_found <= {track.right_seen, track.left_seen};
            if (!both_seen) begin
                r_raw <= (track.left_seen || track.right_seen) ? r_prev : '0;
            end
        end
        if ((r_state == S_CORD) && cres.done) begin
            r_raw <= cres.angle;
        end
        if (r_state == S_MUL0) begin
            r_acc <= ACC_W'(prod);
        end
        if (r_state == S_MUL1) begin
            r_acc <= r_acc + ACC_W'(prod);
        end
        if (r_state == S_GAIN) begin
            r_prod <= prod[PROD_W-1:0];
        end
        if (load_out) begin
            r_left      <= r_drive ? l_clamp : '0;
            r_right     <= r_drive ? r_clamp : '0;
            r_heading   <= r_prev;
            r_out_found <= r_found;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.left_speed         = r_left;
    assign o_res.right_speed        = r_right;
    assign o_res.heading_error_fine = r_heading;
    assign o_res.obstacles_found    = r_out_found;

endmodule
`default_nettype wire

### hdl/nos_checker.sv
`default_nettype none
module nos_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_in_last,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [nos_pkg::SPD_W-1:0]   i_left,
    input logic signed [nos_pkg::SPD_W-1:0]   i_right,
    input logic signed [nos_pkg::ANG_W-1:0]   i_heading,
    input logic [nos_pkg::FOUND_W-1:0]        i_found
);

    // a stalled result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable({i_left, i_right, i_heading, i_found}))
        else $error("result payload changed while stalled");

    // frame end processing blocks pixels on the next cycle
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("pixel taken right after frame end");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat present after reset");

endmodule

bind nearest_obstacle_steering nos_checker u_nos_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_in_last   (i_pix.frame_last),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_left      (o_res.left_speed),
    .i_right     (o_res.right_speed),
    .i_heading   (o_res.heading_error_fine),
    .i_found     (o_res.obstacles_found)
);
`default_nettype wire
